// ----- rtl/teuv_pkg.sv -----
// Shared types, constants and the arctangent table of the equirectangular UV mapper.
`default_nettype none
package teuv_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int UV_FRAC_BITS_DEF = 16;
  localparam int REG_BITS         = 17;
  localparam int CORDIC_ITERS     = 28;
  localparam int DAT_W            = 64;
  localparam int ANG_W            = 36;
  localparam int IDX_W            = 2;

  localparam logic [IDX_W-1:0] REG_SEAM = 2'd0;
  localparam logic [IDX_W-1:0] REG_LOW  = 2'd1;

  localparam logic [REG_BITS-1:0] SEAM_RESET = 17'd45875;
  localparam logic [REG_BITS-1:0] LOW_RESET  = 17'd19661;

  typedef logic signed [DAT_W-1:0] dat_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  typedef struct packed {
    logic valid;
    logic hold;
    dat_t a;
    dat_t b;
    ang_t acc;
  } cst_t;

  localparam ang_t HALF_TURN = ang_t'(64'sd2147483648);

  localparam ang_t ANGLE_TAB [CORDIC_ITERS] = '{
    ang_t'(536870912), ang_t'(316933406), ang_t'(167458907), ang_t'(85004756),
    ang_t'(42667331), ang_t'(21354465), ang_t'(10679838), ang_t'(5340245),
    ang_t'(2670163), ang_t'(1335087), ang_t'(667544), ang_t'(333772),
    ang_t'(166886), ang_t'(83443), ang_t'(41721), ang_t'(20860),
    ang_t'(10430), ang_t'(5215), ang_t'(2607), ang_t'(1303),
    ang_t'(651), ang_t'(325), ang_t'(162), ang_t'(81),
    ang_t'(40), ang_t'(20), ang_t'(10), ang_t'(5)
  };

endpackage
`default_nettype wire

// ----- rtl/teuv_cordic_stage.sv -----
// One registered vectoring step of the CORDIC arctangent.
`default_nettype none
module teuv_cordic_stage #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  teuv_pkg::cst_t     d,
  output teuv_pkg::cst_t     q
);

  logic               valid;
  logic               hold;
  teuv_pkg::dat_t     a;
  teuv_pkg::dat_t     b;
  teuv_pkg::ang_t     acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    hold <= d.hold;
    if (!d.b[teuv_pkg::DAT_W-1]) begin
      a <= d.a + (d.b >>> IDX);
      b <= d.b - (d.a >>> IDX);
      acc <= d.hold ? d.acc : d.acc + teuv_pkg::ANGLE_TAB[IDX];
    end else begin
      a <= d.a - (d.b >>> IDX);
      b <= d.b + (d.a >>> IDX);
      acc <= d.hold ? d.acc : d.acc - teuv_pkg::ANGLE_TAB[IDX];
    end
  end

  assign q = '{valid, hold, a, b, acc};

endmodule
`default_nettype wire

// ----- rtl/teuv_vertex.sv -----
// Per-vertex pipeline: azimuth CORDIC, polar CORDIC and conversion to texture units.
`default_nettype none
module teuv_vertex #(
  parameter int COORD_BITS   = teuv_pkg::COORD_BITS_DEF,
  parameter int UV_FRAC_BITS = teuv_pkg::UV_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] x,
  input  wire logic signed [COORD_BITS-1:0] y,
  input  wire logic signed [COORD_BITS-1:0] z,
  output logic                              out_valid,
  output logic [UV_FRAC_BITS:0]             u,
  output logic [UV_FRAC_BITS:0]             v,
  output logic                              zero
);

  localparam int ITERS    = teuv_pkg::CORDIC_ITERS;
  localparam int PRESCALE = 59 - COORD_BITS;
  localparam int SHL      = (PRESCALE >= 30) ? PRESCALE - 30 : 0;
  localparam int SHR      = (PRESCALE < 30) ? 30 - PRESCALE : 0;
  localparam int PW       = COORD_BITS + 32;
  localparam logic signed [PW-1:0] KFIX = PW'(64'sd1768195363);
  localparam logic [UV_FRAC_BITS:0] HALF_UV = (UV_FRAC_BITS+1)'(1) << (UV_FRAC_BITS - 1);
  localparam logic [33:0] RND = 34'(1) << (31 - UV_FRAC_BITS);
  localparam teuv_pkg::ang_t FULL_TURN = teuv_pkg::ang_t'(64'sd4294967296);

  function automatic logic [UV_FRAC_BITS:0] to_uv(input teuv_pkg::ang_t t);
    logic [32:0] c;
    logic [33:0] s;
    if (t < 0) begin
      c = 33'd0;
    end else if (t > FULL_TURN) begin
      c = FULL_TURN[32:0];
    end else begin
      c = t[32:0];
    end
    s = {1'b0, c} + RND;
    s = s >> (32 - UV_FRAC_BITS);
    return s[UV_FRAC_BITS:0];
  endfunction

  teuv_pkg::cst_t c1 [0:ITERS];
  teuv_pkg::cst_t c2 [0:ITERS];

  logic           p_valid;
  logic           p_hold;
  teuv_pkg::dat_t p_a;
  teuv_pkg::dat_t p_b;
  teuv_pkg::ang_t p_acc;

  teuv_pkg::dat_t yk_d [0:ITERS];
  logic           zv_d [0:ITERS];

  logic           q_valid;
  logic           q_hold;
  teuv_pkg::dat_t q_a;
  teuv_pkg::dat_t q_b;
  teuv_pkg::ang_t q_acc;

  logic [UV_FRAC_BITS:0] u_d [0:ITERS];
  logic                  zv2_d [0:ITERS];

  teuv_pkg::dat_t    xs;
  teuv_pkg::dat_t    zs;
  logic signed [PW-1:0] prod;
  teuv_pkg::dat_t    rk;
  teuv_pkg::dat_t    yk;

  assign xs   = teuv_pkg::dat_t'(x) <<< PRESCALE;
  assign zs   = teuv_pkg::dat_t'(z) <<< PRESCALE;
  assign prod = PW'(y) * KFIX;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid <= in_valid;
      q_valid <= c1[ITERS].valid;
      out_valid <= c2[ITERS].valid;
    end
  end

  always_ff @(posedge clk) begin
    p_hold <= (x == '0) && (z == '0);
    if (xs < 0) begin
      p_a   <= -xs;
      p_b   <= -zs;
      p_acc <= (zs >= 0) ? teuv_pkg::HALF_TURN : -teuv_pkg::HALF_TURN;
    end else begin
      p_a   <= xs;
      p_b   <= zs;
      p_acc <= '0;
    end
    yk_d[0] <= (teuv_pkg::dat_t'(prod) <<< SHL) >>> SHR;
    zv_d[0] <= (x == '0) && (y == '0) && (z == '0);
    for (int i = 0; i < ITERS; i++) begin
      yk_d[i+1] <= yk_d[i];
      zv_d[i+1] <= zv_d[i];
    end
  end

  assign c1[0] = '{p_valid, p_hold, p_a, p_b, p_acc};

  genvar g;
  for (g = 0; g < ITERS; g++) begin : g_cordic
    teuv_cordic_stage #(.IDX(g)) u_az (.clk(clk), .rst(rst), .d(c1[g]), .q(c1[g+1]));
    teuv_cordic_stage #(.IDX(g)) u_po (.clk(clk), .rst(rst), .d(c2[g]), .q(c2[g+1]));
  end

  assign rk = c1[ITERS].a;
  assign yk = yk_d[ITERS];

  always_ff @(posedge clk) begin
    q_hold <= zv_d[ITERS];
    if (yk < 0) begin
      q_a   <= -yk;
      q_b   <= -rk;
      q_acc <= (rk >= 0) ? teuv_pkg::HALF_TURN : -teuv_pkg::HALF_TURN;
    end else begin
      q_a   <= yk;
      q_b   <= rk;
      q_acc <= '0;
    end
    u_d[0]   <= to_uv(c1[ITERS].acc + teuv_pkg::HALF_TURN);
    zv2_d[0] <= zv_d[ITERS];
    for (int i = 0; i < ITERS; i++) begin
      u_d[i+1]   <= u_d[i];
      zv2_d[i+1] <= zv2_d[i];
    end
  end

  assign c2[0] = '{q_valid, q_hold, q_a, q_b, q_acc};

  always_ff @(posedge clk) begin
    zero <= zv2_d[ITERS];
    if (zv2_d[ITERS]) begin
      u <= HALF_UV;
      v <= HALF_UV;
    end else begin
      u <= u_d[ITERS];
      v <= to_uv(c2[ITERS].acc <<< 1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/teuv_seam.sv -----
// One registered seam check on a vertex pair of a triangle.
`default_nettype none
module teuv_seam #(
  parameter int UV_FRAC_BITS = teuv_pkg::UV_FRAC_BITS_DEF,
  parameter int I = 0,
  parameter int J = 1
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire logic [2:0][UV_FRAC_BITS+1:0]         u_in,
  input  wire logic [teuv_pkg::REG_BITS-1:0]        seam_threshold,
  input  wire logic [teuv_pkg::REG_BITS-1:0]        low_threshold,
  output logic                                      out_valid,
  output logic [2:0][UV_FRAC_BITS+1:0]              u_out
);

  localparam int UW = UV_FRAC_BITS + 2;
  localparam int CW = ((UW > teuv_pkg::REG_BITS) ? UW : teuv_pkg::REG_BITS) + 1;
  localparam logic [UW-1:0] ONE = UW'(1) << UV_FRAC_BITS;

  logic [UW-1:0]      ua;
  logic [UW-1:0]      ub;
  logic [UW-1:0]      d;
  logic [2:0][UW-1:0] u_next;

  assign ua = u_in[I];
  assign ub = u_in[J];
  assign d  = (ua >= ub) ? ua - ub : ub - ua;

  always_comb begin
    u_next = u_in;
    if (CW'(d) > CW'(seam_threshold)) begin
      if (CW'(ua) < CW'(low_threshold)) begin
        u_next[I] = ua + ONE;
      end else begin
        u_next[J] = ub + ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    u_out <= u_next;
  end

endmodule
`default_nettype wire

// ----- rtl/triangle_equirect_uv_mapper.sv -----
// Top level of the triangle equirectangular UV mapper with seam repair.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  triangle  | x0..z2                                  | start high, busy low
//  result    | u_first..v_third, zero_vector_flags     | done high for one cycle
//  config    | cfg_index, cfg_data                     | cfg_we high
//
// One triangle is taken every cycle; each result passes through 1 input register,
// 28 azimuth CORDIC stages, 1 polar setup register, 28 polar CORDIC stages, 1
// conversion register and 3 seam checks. Most stages lie in the two 28-step CORDIC chains.
// Reset clears the valid chain and loads the threshold defaults; busy is never high.
`default_nettype none
module triangle_equirect_uv_mapper #(
  parameter int COORD_BITS   = teuv_pkg::COORD_BITS_DEF,
  parameter int UV_FRAC_BITS = teuv_pkg::UV_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_BITS-1:0]        x0,
  input  wire logic signed [COORD_BITS-1:0]        y0,
  input  wire logic signed [COORD_BITS-1:0]        z0,
  input  wire logic signed [COORD_BITS-1:0]        x1,
  input  wire logic signed [COORD_BITS-1:0]        y1,
  input  wire logic signed [COORD_BITS-1:0]        z1,
  input  wire logic signed [COORD_BITS-1:0]        x2,
  input  wire logic signed [COORD_BITS-1:0]        y2,
  input  wire logic signed [COORD_BITS-1:0]        z2,
  input  wire logic                                cfg_we,
  input  wire logic [teuv_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [teuv_pkg::REG_BITS-1:0]       cfg_data,
  output logic                                     done,
  output logic [UV_FRAC_BITS+1:0]                  u_first,
  output logic [UV_FRAC_BITS:0]                    v_first,
  output logic [UV_FRAC_BITS+1:0]                  u_second,
  output logic [UV_FRAC_BITS:0]                    v_second,
  output logic [UV_FRAC_BITS+1:0]                  u_third,
  output logic [UV_FRAC_BITS:0]                    v_third,
  output logic [2:0]                               zero_vector_flags
);

  localparam int UW = UV_FRAC_BITS + 2;
  localparam int SEAM_STAGES = 3;

  logic [teuv_pkg::REG_BITS-1:0] seam_threshold;
  logic [teuv_pkg::REG_BITS-1:0] low_threshold;

  logic [2:0]                    vx_valid;
  logic [2:0][UV_FRAC_BITS:0]    vx_u;
  logic [2:0][UV_FRAC_BITS:0]    vx_v;
  logic [2:0]                    vx_zero;

  logic                          s_valid [0:SEAM_STAGES];
  logic [2:0][UW-1:0]            s_u     [0:SEAM_STAGES];
  logic [2:0][UV_FRAC_BITS:0]    v_d     [0:SEAM_STAGES];
  logic [2:0]                    f_d     [0:SEAM_STAGES];

  logic in_valid;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      seam_threshold <= teuv_pkg::SEAM_RESET;
      low_threshold  <= teuv_pkg::LOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        teuv_pkg::REG_SEAM: seam_threshold <= cfg_data;
        teuv_pkg::REG_LOW:  low_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  teuv_vertex #(.COORD_BITS(COORD_BITS), .UV_FRAC_BITS(UV_FRAC_BITS)) u_vx0 (
    .clk(clk), .rst(rst), .in_valid(in_valid), .x(x0), .y(y0), .z(z0),
    .out_valid(vx_valid[0]), .u(vx_u[0]), .v(vx_v[0]), .zero(vx_zero[0])
  );

  teuv_vertex #(.COORD_BITS(COORD_BITS), .UV_FRAC_BITS(UV_FRAC_BITS)) u_vx1 (
    .clk(clk), .rst(rst), .in_valid(in_valid), .x(x1), .y(y1), .z(z1),
    .out_valid(vx_valid[1]), .u(vx_u[1]), .v(vx_v[1]), .zero(vx_zero[1])
  );

  teuv_vertex #(.COORD_BITS(COORD_BITS), .UV_FRAC_BITS(UV_FRAC_BITS)) u_vx2 (
    .clk(clk), .rst(rst), .in_valid(in_valid), .x(x2), .y(y2), .z(z2),
    .out_valid(vx_valid[2]), .u(vx_u[2]), .v(vx_v[2]), .zero(vx_zero[2])
  );

  assign s_valid[0] = &vx_valid;
  assign s_u[0]     = {UW'(vx_u[2]), UW'(vx_u[1]), UW'(vx_u[0])};
  assign v_d[0]     = vx_v;
  assign f_d[0]     = vx_zero;

  teuv_seam #(.UV_FRAC_BITS(UV_FRAC_BITS), .I(0), .J(1)) u_seam01 (
    .clk(clk), .rst(rst), .in_valid(s_valid[0]), .u_in(s_u[0]),
    .seam_threshold(seam_threshold), .low_threshold(low_threshold),
    .out_valid(s_valid[1]), .u_out(s_u[1])
  );

  teuv_seam #(.UV_FRAC_BITS(UV_FRAC_BITS), .I(0), .J(2)) u_seam02 (
    .clk(clk), .rst(rst), .in_valid(s_valid[1]), .u_in(s_u[1]),
    .seam_threshold(seam_threshold), .low_threshold(low_threshold),
    .out_valid(s_valid[2]), .u_out(s_u[2])
  );

  teuv_seam #(.UV_FRAC_BITS(UV_FRAC_BITS), .I(1), .J(2)) u_seam12 (
    .clk(clk), .rst(rst), .in_valid(s_valid[2]), .u_in(s_u[2]),
    .seam_threshold(seam_threshold), .low_threshold(low_threshold),
    .out_valid(s_valid[3]), .u_out(s_u[3])
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < SEAM_STAGES; i++) begin
      v_d[i+1] <= v_d[i];
      f_d[i+1] <= f_d[i];
    end
  end

  assign done              = s_valid[SEAM_STAGES];
  assign u_first           = s_u[SEAM_STAGES][0];
  assign u_second          = s_u[SEAM_STAGES][1];
  assign u_third           = s_u[SEAM_STAGES][2];
  assign v_first           = v_d[SEAM_STAGES][0];
  assign v_second          = v_d[SEAM_STAGES][1];
  assign v_third           = v_d[SEAM_STAGES][2];
  assign zero_vector_flags = f_d[SEAM_STAGES];

endmodule
`default_nettype wire

// ----- test/triangle_equirect_uv_mapper_tb.sv -----
// Testbench of the triangle UV mapper: self-checking against a built-in angle-based predictor.
`default_nettype none
module triangle_equirect_uv_mapper_tb;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int LAT = 62;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint KFIX = 64'sd1768195363;

  typedef struct {
    logic signed [CB-1:0] c [9];
  } tri_t;

  typedef struct {
    logic [FB+1:0] u [3];
    logic [FB:0] v [3];
    logic [2:0] flags;
  } uv_t;

  logic clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic signed [CB-1:0] x0 = 0, y0 = 0, z0 = 0, x1 = 0, y1 = 0, z1 = 0;
  logic signed [CB-1:0] x2 = 0, y2 = 0, z2 = 0;
  logic [teuv_pkg::IDX_W-1:0] cfg_index = '0;
  logic [teuv_pkg::REG_BITS-1:0] cfg_data = '0;
  logic busy, done;
  logic [FB+1:0] u_first, u_second, u_third;
  logic [FB:0] v_first, v_second, v_third;
  logic [2:0] zero_vector_flags;

  triangle_equirect_uv_mapper dut (.*);

  tri_t pending_tris[$];
  uv_t expected_uv[$];
  longint seam_thr = teuv_pkg::SEAM_RESET, low_thr = teuv_pkg::LOW_RESET;
  int errors = 0;
  bit feeding = 0;

  initial forever #6 clk = ~clk;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(longint b, longint a, output longint mag);
    longint acc = 0, na, nb;
    if (a == 0 && b == 0) begin
      mag = 0;
      return 0;
    end
    if (a < 0) begin
      acc = (b >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      a = -a;
      b = -b;
    end
    for (int i = 0; i < teuv_pkg::CORDIC_ITERS; i++) begin
      if (b >= 0) begin
        na = a + fshift(b, i);
        nb = b - fshift(a, i);
        acc += longint'(teuv_pkg::ANGLE_TAB[i]);
      end else begin
        na = a - fshift(b, i);
        nb = b + fshift(a, i);
        acc -= longint'(teuv_pkg::ANGLE_TAB[i]);
      end
      a = na;
      b = nb;
    end
    mag = a;
    return acc;
  endfunction

  function automatic longint turn_to_fixed(longint t);
    if (t < 0) t = 0;
    if (t > (64'sd1 <<< 32)) t = 64'sd1 <<< 32;
    return (t + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
  endfunction

  function automatic uv_t predict_uv(tri_t t);
    uv_t r;
    longint us [3], vs [3], x, y, z, rk, m2, ang, d;
    int pa [3] = '{0, 0, 1};
    int pb [3] = '{1, 2, 2};
    r.flags = 0;
    for (int k = 0; k < 3; k++) begin
      x = t.c[3*k]; y = t.c[3*k+1]; z = t.c[3*k+2];
      if (x == 0 && y == 0 && z == 0) begin
        us[k] = ONE / 2;
        vs[k] = ONE / 2;
        r.flags[k] = 1;
      end else begin
        ang = vector_angle(z <<< (59 - CB), x <<< (59 - CB), rk);
        us[k] = turn_to_fixed(ang + (64'sd1 <<< 31));
        ang = vector_angle(rk, (y * KFIX) <<< (59 - CB - 30), m2);
        vs[k] = turn_to_fixed(ang * 2);
      end
    end
    for (int p = 0; p < 3; p++) begin
      d = us[pa[p]] - us[pb[p]];
      if (d < 0) d = -d;
      if (d > seam_thr) begin
        if (us[pa[p]] < low_thr) us[pa[p]] += ONE;
        else us[pb[p]] += ONE;
      end
    end
    for (int k = 0; k < 3; k++) begin
      r.u[k] = us[k][FB+1:0];
      r.v[k] = vs[k][FB:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver: bursts and gaps
  int gap = 0, burst = 0;
  always @(negedge clk) begin
    if (!rst && feeding && pending_tris.size() > 0 && gap == 0) begin
      tri_t t;
      t = pending_tris.pop_front();
      {x0, y0, z0, x1, y1, z1, x2, y2, z2} =
        {t.c[0], t.c[1], t.c[2], t.c[3], t.c[4], t.c[5], t.c[6], t.c[7], t.c[8]};
      expected_uv = {expected_uv, predict_uv(t)};
      start <= 1;
      if (burst > 0) burst--;
      else begin
        burst = $urandom_range(0, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      start <= 0;
      if (gap > 0) gap--;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && start && busy) report_mismatch("busy at start", 1, 0);
    if (!rst && done) begin
      if (expected_uv.size() == 0) report_mismatch("unexpected transaction", 1, 0);
      else begin
        uv_t e;
        e = expected_uv.pop_front();
        if (u_first !== e.u[0]) report_mismatch("u_first", u_first, e.u[0]);
        if (v_first !== e.v[0]) report_mismatch("v_first", v_first, e.v[0]);
        if (u_second !== e.u[1]) report_mismatch("u_second", u_second, e.u[1]);
        if (v_second !== e.v[1]) report_mismatch("v_second", v_second, e.v[1]);
        if (u_third !== e.u[2]) report_mismatch("u_third", u_third, e.u[2]);
        if (v_third !== e.v[2]) report_mismatch("v_third", v_third, e.v[2]);
        if (zero_vector_flags !== e.flags)
          report_mismatch("flags", zero_vector_flags, e.flags);
      end
    end
  end

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return CB'($urandom_range(0, 40) - 20);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    for (int i = 0; i < 9; i++) t.c[i] = rand_coord();
    // aim both sides of the seam
    if ($urandom_range(0, 3) == 0) begin
      t.c[0] = -CB'($urandom_range(1, 30000)); t.c[2] = CB'($urandom_range(0, 500));
      t.c[3] = -CB'($urandom_range(1, 30000)); t.c[5] = -CB'($urandom_range(1, 500));
    end
    return t;
  endfunction

  task automatic run_phase(int n, bit directed);
    tri_t t;
    if (directed) begin
      for (int k = 0; k < 16; k++) begin
        for (int i = 0; i < 9; i++) t.c[i] = 0;
        case (k)
          1: t.c = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh7fff, 16'sh8000, 16'sh7fff};
          2: t.c = '{0, 100, 0, 0, -100, 0, 0, 16'sh7fff, 0};
          3: t.c = '{-100, 0, 0, 100, 0, 0, -1, 0, 0};
          4: t.c = '{-100, 0, 1, -100, 0, -1, 100, 0, 0};
          5: t.c = '{-100, 0, -1, -100, 0, 1, 0, 0, 0};
          6: t.c = '{0, 0, 0, 1, 1, 1, 0, 0, 0};
          7: t.c = '{1, 0, 0, 0, 0, 1, 0, 0, -1};
          8: t.c = '{16'sh8000, 0, 0, 16'sh8000, 0, 16'sh8000, 16'sh8000, 0, 16'sh7fff};
          9: t.c = '{0, 0, 1, 0, 0, -1, -1, -1, -1};
          default: if (k > 9) t = rand_tri();
        endcase
        pending_tris = {pending_tris, t};
      end
    end
    for (int i = 0; i < n; i++) pending_tris = {pending_tris, rand_tri()};
    feeding = 1;
    wait (pending_tris.size() == 0 && expected_uv.size() == 0);
    feeding = 0;
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [teuv_pkg::IDX_W-1:0] idx,
                           logic [teuv_pkg::REG_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == teuv_pkg::REG_SEAM) seam_thr = val;
    else if (idx == teuv_pkg::REG_LOW) low_thr = val;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 0;
    run_phase(200, 1);
    write_reg(teuv_pkg::REG_SEAM, 17'd0);
    write_reg(teuv_pkg::REG_LOW, 17'h1ffff);
    write_reg(2'd2, 17'd5);
    write_reg(2'd3, 17'd7);
    run_phase(150, 1);
    write_reg(teuv_pkg::REG_SEAM, 17'h1ffff);
    write_reg(teuv_pkg::REG_LOW, 17'd0);
    run_phase(100, 0);
    write_reg(teuv_pkg::REG_SEAM, 17'd65536);
    write_reg(teuv_pkg::REG_LOW, 17'd65536);
    run_phase(100, 0);
    write_reg(teuv_pkg::REG_SEAM, teuv_pkg::REG_BITS'($urandom_range(0, 65536)));
    write_reg(teuv_pkg::REG_LOW, teuv_pkg::REG_BITS'($urandom_range(0, 65536)));
    run_phase(200, 0);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ----- triangle_equirect_uv_mapper.f -----
rtl/teuv_pkg.sv
rtl/teuv_cordic_stage.sv
rtl/teuv_vertex.sv
rtl/teuv_seam.sv
rtl/triangle_equirect_uv_mapper.sv
test/triangle_equirect_uv_mapper_tb.sv
